[rtl/bdf_pkg.sv]
// Shared constants, codes and types of the binaural dual FIR block.
package bdf_pkg;

    localparam int DEF_MAX_TAPS    = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_W         = 9;
    localparam int TAP_INDEX_W   = 8;
    localparam int FUNC_W        = 2;

    localparam logic [CFG_W-1:0] TAPS_RESET = 9'd256;

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        K_SAMPLE,
        K_LOAD_LEFT,
        K_LOAD_RIGHT
    } t_kind;

    // Oldest queued item as offered to the back end.
    typedef struct packed {
        logic                   valid;
        t_kind                  kind;
        logic [TAP_INDEX_W-1:0] tap_index;
    } t_q_head;

    // Status returned by the back end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

[rtl/bdf_front.sv]
// Front end: accepts input items, classifies them and queues the ones that do work.
module bdf_front #(
    parameter int MAX_TAPS    = bdf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = bdf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bdf_pkg::FUNC_W-1:0]      i_func,
    input  logic [bdf_pkg::TAP_INDEX_W-1:0] i_tap_index,
    input  logic [SAMPLE_BITS-1:0]          i_value,
    input  bdf_pkg::t_back_stat             i_stat,
    output bdf_pkg::t_q_head                o_head,
    output logic [SAMPLE_BITS-1:0]          o_head_value
);
    import bdf_pkg::*;

    logic [QPTR_W-1:0]      r_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr;
    logic [QCNT_W-1:0]      r_count;
    t_kind                  r_kind [QUEUE_DEPTH];
    logic [TAP_INDEX_W-1:0] r_idx  [QUEUE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_val  [QUEUE_DEPTH];

    logic  accept;
    logic  keep;
    logic  push;
    logic  pop;
    logic  idx_ok;
    t_kind kind;

    assign o_stall = i_stat.clearing || (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept  = i_valid && !o_stall;
    assign idx_ok  = 32'(i_tap_index) < 32'(MAX_TAPS);

    // Unused function codes and loads beyond the tap store are dropped here.
    always_comb begin
        kind = K_SAMPLE;
        keep = 1'b0;
        unique case (i_func)
            FUNC_SAMPLE: begin
                kind = K_SAMPLE;
                keep = 1'b1;
            end
            FUNC_LOAD_LEFT: begin
                kind = K_LOAD_LEFT;
                keep = idx_ok;
            end
            FUNC_LOAD_RIGHT: begin
                kind = K_LOAD_RIGHT;
                keep = idx_ok;
            end
            default: begin
                kind = K_SAMPLE;
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;
    assign pop  = i_stat.pop;

    assign o_head.valid     = (r_count != '0);
    assign o_head.kind      = r_kind[r_rd_ptr];
    assign o_head.tap_index = r_idx[r_rd_ptr];
    assign o_head_value     = r_val[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_wr_ptr] <= kind;
            r_idx[r_wr_ptr]  <= i_tap_index;
            r_val[r_wr_ptr]  <= i_value;
        end
    end

endmodule

[rtl/bdf_back.sv]
// Back end: delay line and tap stores, the shared multiply-accumulate sequencer and the result register.
module bdf_back #(
    parameter int MAX_TAPS    = bdf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = bdf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bdf_pkg::CFG_W-1:0]  i_cfg_taps_in_use,
    input  bdf_pkg::t_q_head           i_head,
    input  logic [SAMPLE_BITS-1:0]     i_head_value,
    output bdf_pkg::t_back_stat        o_stat,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [SAMPLE_BITS-1:0]     o_left_out,
    output logic [SAMPLE_BITS-1:0]     o_right_out
);
    import bdf_pkg::*;

    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int FRAC_W = SAMPLE_BITS - 1;

    localparam logic signed [ACC_W:0] SAT_MAX =
        {{(ACC_W - SAMPLE_BITS + 2){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SAT_MIN  = ~SAT_MAX;
    localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W + 1)'(1) << (FRAC_W - 1);
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(MAX_TAPS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MAC   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]              r_taps_in_use;
    logic [IDX_W-1:0]              r_head;
    logic [IDX_W-1:0]              r_clr;
    logic [IDX_W-1:0]              r_j;
    logic [IDX_W-1:0]              r_pos;
    logic [IDX_W-1:0]              r_last;
    logic                          r_v1;
    logic                          r_v2;
    logic signed [SAMPLE_BITS-1:0] r_hist_q;
    logic signed [SAMPLE_BITS-1:0] r_tl_q;
    logic signed [SAMPLE_BITS-1:0] r_tr_q;
    logic signed [PROD_W-1:0]      r_pl;
    logic signed [PROD_W-1:0]      r_pr;
    logic signed [ACC_W-1:0]       r_accl;
    logic signed [ACC_W-1:0]       r_accr;
    logic                          r_o_valid;
    logic [SAMPLE_BITS-1:0]        r_left;
    logic [SAMPLE_BITS-1:0]        r_right;

    logic [SAMPLE_BITS-1:0] r_hist_mem  [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] r_left_mem  [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] r_right_mem [MAX_TAPS];

    logic                   clearing;
    logic                   pop;
    logic                   hist_we;
    logic                   left_we;
    logic                   right_we;
    logic [IDX_W-1:0]       hist_waddr;
    logic [IDX_W-1:0]       tap_waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [31:0]            taps_clamped;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       pos_dec;
    logic [IDX_W-1:0]       head_inc;
    logic                   out_free;

    function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] biased;
        logic signed [ACC_W:0] shifted;
        logic signed [ACC_W:0] sat;
        biased  = (ACC_W + 1)'(acc) + HALF_LSB;
        shifted = biased >>> FRAC_W;
        if (shifted > SAT_MAX) begin
            sat = SAT_MAX;
        end else if (shifted < SAT_MIN) begin
            sat = SAT_MIN;
        end else begin
            sat = shifted;
        end
        return sat[SAMPLE_BITS-1:0];
    endfunction

    assign clearing = (r_state == S_CLEAR);
    assign pop      = (r_state == S_IDLE) && i_head.valid;
    assign out_free = !r_o_valid || !i_stall;

    assign o_stat.pop      = pop;
    assign o_stat.clearing = clearing;

    // The clearing pass after reset shares the write ports with the items.
    assign hist_we    = clearing || (pop && (i_head.kind == K_SAMPLE));
    assign left_we    = clearing || (pop && (i_head.kind == K_LOAD_LEFT));
    assign right_we   = clearing || (pop && (i_head.kind == K_LOAD_RIGHT));
    assign hist_waddr = clearing ? r_clr : r_head;
    assign tap_waddr  = clearing ? r_clr : IDX_W'(i_head.tap_index);
    assign wdata      = clearing ? '0 : i_head_value;

    assign pos_dec  = (r_pos == '0) ? LAST_IDX : r_pos - IDX_W'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);

    always_comb begin
        taps_clamped = 32'(r_taps_in_use);
        if (taps_clamped == 32'd0) begin
            taps_clamped = 32'd1;
        end else if (taps_clamped > 32'(MAX_TAPS)) begin
            taps_clamped = 32'(MAX_TAPS);
        end
        last_idx = IDX_W'(taps_clamped - 32'd1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop && (i_head.kind == K_SAMPLE)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_j == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_taps_in_use <= TAPS_RESET;
            r_head        <= '0;
            r_clr         <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_MAC);
            r_v2    <= r_v1;
            if (i_cfg_we) begin
                r_taps_in_use <= i_cfg_taps_in_use;
            end
            if (clearing) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (pop && (i_head.kind == K_SAMPLE)) begin
                r_head <= head_inc;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Tap sequencer: one address pair per cycle, then read, multiply and add stages.
    always_ff @(posedge i_clk) begin
        if (pop && (i_head.kind == K_SAMPLE)) begin
            r_j    <= '0;
            r_pos  <= r_head;
            r_last <= last_idx;
            r_accl <= '0;
            r_accr <= '0;
        end else begin
            if (r_state == S_MAC) begin
                r_j   <= r_j + IDX_W'(1);
                r_pos <= pos_dec;
            end
            if (r_v2) begin
                r_accl <= r_accl + ACC_W'(r_pl);
                r_accr <= r_accr + ACC_W'(r_pr);
            end
        end
        r_pl <= r_tl_q * r_hist_q;
        r_pr <= r_tr_q * r_hist_q;
        if ((r_state == S_DONE) && out_free) begin
            r_left  <= round_sat(r_accl);
            r_right <= round_sat(r_accr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= wdata;
        end
        r_hist_q <= r_hist_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (left_we) begin
            r_left_mem[tap_waddr] <= wdata;
        end
        r_tl_q <= r_left_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (right_we) begin
            r_right_mem[tap_waddr] <= wdata;
        end
        r_tr_q <= r_right_mem[r_j];
    end

    assign o_valid     = r_o_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

endmodule

[rtl/binaural_dual_fir.sv]
// Top level of the binaural dual FIR: front end, item queue and multiply-accumulate back end.
//
// A mono stream runs through one shared delay line into a left and a right FIR filter in
// Q1.15, each sum kept exact, rounded to nearest (ties upward) and saturated. For an audio
// item one shared left/right multiplier pair works through n taps one per cycle, n being
// taps_in_use held to the range 1 to MAX_TAPS, reading tap and history memories with one
// write and one read port each behind a read, multiply and accumulate pipeline; a tap load
// is written to its tap memory when it leaves the queue. A two-entry queue lets items be
// accepted while a sum is in progress, and the result register holds one finished result
// while the next is computed. After reset the block clears every entry of its three
// memories, one entry per cycle, and stalls input meanwhile; configuration writes are taken
// at any time but should only be made while the block is idle.
module binaural_dual_fir #(
    parameter int MAX_TAPS    = bdf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = bdf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bdf_pkg::CFG_W-1:0]       i_cfg_taps_in_use,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bdf_pkg::FUNC_W-1:0]      i_func,
    input  logic [bdf_pkg::TAP_INDEX_W-1:0] i_tap_index,
    input  logic [SAMPLE_BITS-1:0]          i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [SAMPLE_BITS-1:0]          o_left_out,
    output logic [SAMPLE_BITS-1:0]          o_right_out
);
    import bdf_pkg::*;

    t_q_head                head;
    logic [SAMPLE_BITS-1:0] head_value;
    t_back_stat             stat;

    assign o_cfg_ready = 1'b1;

    bdf_front #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_tap_index  (i_tap_index),
        .i_value      (i_value),
        .i_stat       (stat),
        .o_head       (head),
        .o_head_value (head_value)
    );

    bdf_back #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_taps_in_use (i_cfg_taps_in_use),
        .i_head            (head),
        .i_head_value      (head_value),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_left_out        (o_left_out),
        .o_right_out       (o_right_out)
    );

endmodule
